// ===== rtl/core/hfbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfbt_pkg
// Shared types and codes of the HPACK field block tokenizer.
// ----------------------------------------------------------------------------
package hfbt_pkg;

   localparam int RSP_DEPTH_DEFAULT = 4;
   localparam logic [31:0] ALLOWED_SIZE_RESET = 32'd4096;

   typedef enum logic [2:0] {
      PH_START      = 3'd0,
      PH_INT        = 3'd1,
      PH_NAME_LEN   = 3'd2,
      PH_VALUE_LEN  = 3'd3,
      PH_NAME_DATA  = 3'd4,
      PH_VALUE_DATA = 3'd5,
      PH_SKIP       = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      CTX_INDEXED   = 3'd0,
      CTX_LIT_ADD   = 3'd1,
      CTX_LIT_PLAIN = 3'd2,
      CTX_SIZE      = 3'd3,
      CTX_NAME_LEN  = 3'd4,
      CTX_VALUE_LEN = 3'd5
   } ctx_type;

   typedef enum logic [2:0] {
      KIND_INDEXED   = 3'd0,
      KIND_NAME_IDX  = 3'd1,
      KIND_STR_HDR   = 3'd2,
      KIND_PAYLOAD   = 3'd3,
      KIND_SIZE_UPD  = 3'd4,
      KIND_BLOCK_OK  = 3'd5,
      KIND_BLOCK_ERR = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_TRUNC    = 2'd1,
      ERR_OVERFLOW = 2'd2,
      ERR_SIZE     = 2'd3
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [31:0] token_value;
      logic        huffman_flag;
      logic        adds_to_table;
      logic        string_is_value;
      logic [1:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// ===== rtl/core/hfbt_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfbt_parser
// Per-byte representation parser: prefixed integers, strings, size updates,
// error latching and block end reporting. Gives up to two results per byte.
// ----------------------------------------------------------------------------
module hfbt_parser
   import hfbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  req_type     step_data,
   input  logic [31:0] allowed_size,
   output push_type    push
);

   phase_type   phase_ff, phase_in;
   ctx_type     ctx_ff, ctx_in;
   logic [31:0] accum_ff, accum_in;
   logic [4:0]  shift_ff, shift_in;
   logic [31:0] remain_ff, remain_in;
   logic        pend_ff, pend_in;
   logic        saw_ff, saw_in;
   logic [1:0]  upd_ff, upd_in;
   logic [31:0] first_ff, first_in;
   logic [1:0]  err_ff, err_in;

   always_comb begin
      logic [7:0]  b;
      logic        beg;
      ctx_type     beg_ctx;
      logic [7:0]  beg_mask;
      logic [7:0]  beg_v;
      logic        fin;
      ctx_type     fin_ctx;
      logic [31:0] fin_v;
      logic        lat;
      err_type     lat_code;
      logic        tok_valid;
      rsp_type     tok;
      rsp_type     fin_rsp;
      logic [6:0]  chunk;
      logic [31:0] addend;
      logic [32:0] sum;
      logic [5:0]  shift6;

      b         = step_data.data_byte;
      beg       = 1'b0;
      beg_ctx   = CTX_INDEXED;
      beg_mask  = 8'h7f;
      beg_v     = '0;
      fin       = 1'b0;
      fin_ctx   = CTX_INDEXED;
      fin_v     = '0;
      lat       = 1'b0;
      lat_code  = ERR_NONE;
      tok_valid = 1'b0;
      tok       = '0;
      fin_rsp   = '0;
      chunk     = b[6:0];
      addend    = 32'(chunk) << shift_ff;
      sum       = {1'b0, accum_ff} + {1'b0, addend};
      shift6    = {1'b0, shift_ff} + 6'd7;

      phase_in  = phase_ff;
      ctx_in    = ctx_ff;
      accum_in  = accum_ff;
      shift_in  = shift_ff;
      remain_in = remain_ff;
      pend_in   = pend_ff;
      saw_in    = saw_ff;
      upd_in    = upd_ff;
      first_in  = first_ff;
      err_in    = err_ff;

      unique case (phase_ff)
         PH_START: begin
            if (b[7]) begin
               saw_in   = 1'b1;
               beg      = 1'b1;
               beg_ctx  = CTX_INDEXED;
               beg_mask = 8'h7f;
            end else if (b[6]) begin
               saw_in   = 1'b1;
               beg      = 1'b1;
               beg_ctx  = CTX_LIT_ADD;
               beg_mask = 8'h3f;
            end else if (b[5]) begin
               if (saw_ff || upd_ff >= 2'd2) begin
                  lat      = 1'b1;
                  lat_code = ERR_SIZE;
               end else begin
                  beg      = 1'b1;
                  beg_ctx  = CTX_SIZE;
                  beg_mask = 8'h1f;
               end
            end else begin
               saw_in   = 1'b1;
               beg      = 1'b1;
               beg_ctx  = CTX_LIT_PLAIN;
               beg_mask = 8'h0f;
            end
         end
         PH_INT: begin
            if (shift_ff > 5'd28 || (shift_ff >= 5'd28 && chunk > 7'h0f) || sum[32]) begin
               lat      = 1'b1;
               lat_code = ERR_OVERFLOW;
            end else begin
               accum_in = sum[31:0];
               if (!b[7]) begin
                  fin     = 1'b1;
                  fin_ctx = ctx_ff;
                  fin_v   = sum[31:0];
               end else begin
                  shift_in = shift6[4:0];
                  if (shift6 > 6'd28) begin
                     lat      = 1'b1;
                     lat_code = ERR_OVERFLOW;
                  end
               end
            end
         end
         PH_NAME_LEN, PH_VALUE_LEN: begin
            pend_in  = b[7];
            beg      = 1'b1;
            beg_ctx  = (phase_ff == PH_VALUE_LEN) ? CTX_VALUE_LEN : CTX_NAME_LEN;
            beg_mask = 8'h7f;
         end
         PH_NAME_DATA, PH_VALUE_DATA: begin
            tok_valid           = 1'b1;
            tok.token_kind      = KIND_PAYLOAD;
            tok.token_value     = {24'd0, b};
            tok.string_is_value = (phase_ff == PH_VALUE_DATA);
            remain_in           = remain_ff - 32'd1;
            if (remain_in == 32'd0) begin
               phase_in = (phase_ff == PH_VALUE_DATA) ? PH_START : PH_VALUE_LEN;
            end
         end
         default: begin
         end
      endcase

      if (beg) begin
         beg_v = b & beg_mask;
         if (beg_v < beg_mask) begin
            fin     = 1'b1;
            fin_ctx = beg_ctx;
            fin_v   = {24'd0, beg_v};
         end else begin
            ctx_in   = beg_ctx;
            accum_in = {24'd0, beg_v};
            shift_in = '0;
            phase_in = PH_INT;
         end
      end

      if (fin) begin
         fin_rsp.token_value = fin_v;
         case (fin_ctx)
            CTX_INDEXED: begin
               tok_valid          = 1'b1;
               fin_rsp.token_kind = KIND_INDEXED;
               phase_in           = PH_START;
            end
            CTX_LIT_ADD, CTX_LIT_PLAIN: begin
               tok_valid             = 1'b1;
               fin_rsp.token_kind    = KIND_NAME_IDX;
               fin_rsp.adds_to_table = (fin_ctx == CTX_LIT_ADD);
               phase_in              = (fin_v == 32'd0) ? PH_NAME_LEN : PH_VALUE_LEN;
            end
            CTX_SIZE: begin
               if (fin_v > allowed_size || (upd_ff == 2'd1 && fin_v < first_ff)) begin
                  lat      = 1'b1;
                  lat_code = ERR_SIZE;
               end else begin
                  if (upd_ff == 2'd0) begin
                     first_in = fin_v;
                  end
                  upd_in             = upd_ff + 2'd1;
                  tok_valid          = 1'b1;
                  fin_rsp.token_kind = KIND_SIZE_UPD;
                  phase_in           = PH_START;
               end
            end
            CTX_NAME_LEN, CTX_VALUE_LEN: begin
               tok_valid               = 1'b1;
               fin_rsp.token_kind      = KIND_STR_HDR;
               fin_rsp.huffman_flag    = pend_in;
               fin_rsp.string_is_value = (fin_ctx == CTX_VALUE_LEN);
               remain_in               = fin_v;
               if (fin_v != 32'd0) begin
                  phase_in = (fin_ctx == CTX_VALUE_LEN) ? PH_VALUE_DATA : PH_NAME_DATA;
               end else begin
                  phase_in = (fin_ctx == CTX_VALUE_LEN) ? PH_START : PH_VALUE_LEN;
               end
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
         tok = fin_rsp;
      end

      if (lat) begin
         if (err_ff == ERR_NONE) begin
            err_in = lat_code;
         end
         phase_in = PH_SKIP;
      end

      push        = '0;
      push.first  = tok;
      push.second = '0;
      if (step_data.block_end) begin
         if (err_in != ERR_NONE) begin
            push.second.token_kind = KIND_BLOCK_ERR;
            push.second.error_code = err_in;
         end else if (phase_in != PH_START) begin
            push.second.token_kind = KIND_BLOCK_ERR;
            push.second.error_code = ERR_TRUNC;
         end else begin
            push.second.token_kind = KIND_BLOCK_OK;
         end
         push.second.last_of_run = 1'b1;
         if (tok_valid) begin
            push.count = 2'd2;
         end else begin
            push.first = push.second;
            push.count = 2'd1;
         end
         phase_in  = PH_START;
         ctx_in    = CTX_INDEXED;
         accum_in  = '0;
         shift_in  = '0;
         remain_in = '0;
         pend_in   = 1'b0;
         saw_in    = 1'b0;
         upd_in    = '0;
         first_in  = '0;
         err_in    = ERR_NONE;
      end else if (tok_valid) begin
         push.first.last_of_run = 1'b1;
         push.count             = 2'd1;
      end

      if (!step_en) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         ctx_ff    <= CTX_INDEXED;
         accum_ff  <= '0;
         shift_ff  <= '0;
         remain_ff <= '0;
         pend_ff   <= 1'b0;
         saw_ff    <= 1'b0;
         upd_ff    <= '0;
         first_ff  <= '0;
         err_ff    <= ERR_NONE;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         ctx_ff    <= ctx_in;
         accum_ff  <= accum_in;
         shift_ff  <= shift_in;
         remain_ff <= remain_in;
         pend_ff   <= pend_in;
         saw_ff    <= saw_in;
         upd_ff    <= upd_in;
         first_ff  <= first_in;
         err_ff    <= err_in;
      end
   end

endmodule

// ===== rtl/core/hfbt_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfbt_rsp_fifo
// Result queue: takes up to two results per cycle, gives one per transaction.
// ----------------------------------------------------------------------------
module hfbt_rsp_fifo
   import hfbt_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type       mem [DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] wptr_next;
   logic          pop;

   function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign wptr_next = incr(wptr_ff);
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[rptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = pop ? incr(rptr_ff) : rptr_ff;
      count_in = count_ff + CW'(push.count) - CW'(pop);
      case (push.count)
         2'd1:    wptr_in = wptr_next;
         2'd2:    wptr_in = incr(wptr_next);
         default: wptr_in = wptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/hpack_field_block_tokenizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_field_block_tokenizer_core
// HPACK field block tokenizer: bytes in, representation tokens out.
// ----------------------------------------------------------------------------
// One field block byte per transaction; a byte waits in the input register
// until the result queue of RSP_DEPTH entries has room, then is parsed and
// gives up to two results, which enter the queue and are offered from it. A
// byte is taken every cycle while the queue has room for two results, so the
// sustained rate is one byte per cycle when results are drained at one per
// cycle; a byte with a token and the block end result queues two results. The
// user must write allowed_table_size through the csr port while the block is
// idle; the block itself does not enforce this. It resets to 4096.
module hpack_field_block_tokenizer_core
   import hfbt_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   req_type     in_ff;
   logic        full_ff, full_in;
   logic [31:0] allowed_ff;
   logic        room;
   logic        step_en;
   logic        accept;
   push_type    push;

   assign csr_ready = 1'b1;
   assign step_en   = full_ff && room;
   assign req_stall = full_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign full_in   = accept ? 1'b1 : (step_en ? 1'b0 : full_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff    <= 1'b0;
         allowed_ff <= ALLOWED_SIZE_RESET;
      end else begin
         full_ff <= full_in;
         if (csr_valid && csr_ready) begin
            allowed_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   hfbt_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .step_data    (in_ff),
      .allowed_size (allowed_ff),
      .push         (push)
   );

   hfbt_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/hpack_field_block_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_field_block_tokenizer_core_tb
// Self-checking bench for the HPACK field block tokenizer. A directed table
// covers index zero, the largest 32-bit integer, misplaced and bad size
// updates, overflow and truncation. Then random field blocks follow, mostly
// well formed with random content and partly broken, under several table size
// limits. An in-bench tokenizer predicts every token, and both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module hpack_field_block_tokenizer_core_tb;
   import hfbt_pkg::*;

   typedef struct {
      req_type req;
      int      n_typed;   // < 0: tokens come from the tokenizer model
      rsp_type r0;
      rsp_type r1;
   } byte_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   byte_row_type byte_rows[$];
   byte_row_type sent_rows[$];
   rsp_type     pending_tokens[$];
   rsp_type     step_tokens[$];
   int          mismatch_count = 0;
   bit          no_idle = 1'b0;
   bit          long_hold_req = 1'b0;

   // tokenizer model state
   logic [31:0] table_limit;
   phase_type   st_phase;
   ctx_type     st_ctx;
   logic [31:0] st_accum;
   int          st_shift;
   logic [31:0] st_remaining;
   logic        st_huff;
   logic        st_saw_header;
   logic [1:0]  st_updates;
   logic [31:0] st_first_size;
   err_type     st_error;

   always #10 clock = ~clock;

   hpack_field_block_tokenizer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   function automatic rsp_type mk_token(kind_type k, logic [31:0] v, logic h, logic a,
                                        logic s, err_type e, logic l);
      rsp_type t;
      t.token_kind      = k;
      t.token_value     = v;
      t.huffman_flag    = h;
      t.adds_to_table   = a;
      t.string_is_value = s;
      t.error_code      = e;
      t.last_of_run     = l;
      return t;
   endfunction

   // ---------------- tokenizer model ----------------

   function automatic void clear_block();
      st_phase      = PH_START;
      st_ctx        = CTX_INDEXED;
      st_accum      = '0;
      st_shift      = 0;
      st_remaining  = '0;
      st_huff       = 1'b0;
      st_saw_header = 1'b0;
      st_updates    = '0;
      st_first_size = '0;
      st_error      = ERR_NONE;
   endfunction

   function automatic void emit_token(kind_type k, logic [31:0] v, logic h, logic a,
                                      logic s, err_type e);
      step_tokens.push_back(mk_token(k, v, h, a, s, e, 1'b0));
   endfunction

   function automatic void latch_error(err_type code);
      if (st_error == ERR_NONE) st_error = code;
      st_phase = PH_SKIP;
   endfunction

   function automatic void finish_int(ctx_type c, logic [31:0] v);
      logic isv;
      case (c)
         CTX_INDEXED: begin
            emit_token(KIND_INDEXED, v, 1'b0, 1'b0, 1'b0, ERR_NONE);
            st_phase = PH_START;
         end
         CTX_LIT_ADD, CTX_LIT_PLAIN: begin
            emit_token(KIND_NAME_IDX, v, 1'b0, c == CTX_LIT_ADD, 1'b0, ERR_NONE);
            st_phase = (v == 0) ? PH_NAME_LEN : PH_VALUE_LEN;
         end
         CTX_SIZE: begin
            if (v > table_limit || (st_updates == 2'd1 && v < st_first_size)) begin
               latch_error(ERR_SIZE);
            end else begin
               if (st_updates == 2'd0) st_first_size = v;
               st_updates = st_updates + 2'd1;
               emit_token(KIND_SIZE_UPD, v, 1'b0, 1'b0, 1'b0, ERR_NONE);
               st_phase = PH_START;
            end
         end
         CTX_NAME_LEN, CTX_VALUE_LEN: begin
            isv = (c == CTX_VALUE_LEN);
            emit_token(KIND_STR_HDR, v, st_huff, 1'b0, isv, ERR_NONE);
            st_remaining = v;
            if (v != 0) st_phase = isv ? PH_VALUE_DATA : PH_NAME_DATA;
            else st_phase = isv ? PH_START : PH_VALUE_LEN;
         end
         default: st_phase = PH_START;
      endcase
   endfunction

   function automatic void begin_int(ctx_type c, logic [7:0] mask, logic [7:0] b);
      logic [7:0] v;
      v = b & mask;
      if (v < mask) begin
         finish_int(c, {24'd0, v});
      end else begin
         st_ctx   = c;
         st_accum = {24'd0, v};
         st_shift = 0;
         st_phase = PH_INT;
      end
   endfunction

   function automatic void continue_int(logic [7:0] b);
      logic [31:0] chunk;
      logic [31:0] addend;
      chunk = {25'd0, b[6:0]};
      if (st_shift > 28 || (st_shift >= 28 && chunk > 32'h0f)) begin
         latch_error(ERR_OVERFLOW);
      end else begin
         addend = chunk << st_shift;
         if (st_accum > 32'hFFFFFFFF - addend) begin
            latch_error(ERR_OVERFLOW);
         end else begin
            st_accum = st_accum + addend;
            if (!b[7]) begin
               finish_int(st_ctx, st_accum);
            end else begin
               st_shift = st_shift + 7;
               if (st_shift > 28) latch_error(ERR_OVERFLOW);
            end
         end
      end
   endfunction

   function automatic void tokenize_byte(req_type r);
      logic [7:0] b;
      logic       isv;
      b = r.data_byte;
      step_tokens.delete();
      case (st_phase)
         PH_START: begin
            if (b[7]) begin
               st_saw_header = 1'b1;
               begin_int(CTX_INDEXED, 8'h7f, b);
            end else if (b[6]) begin
               st_saw_header = 1'b1;
               begin_int(CTX_LIT_ADD, 8'h3f, b);
            end else if ((b & 8'he0) == 8'h20) begin
               if (st_saw_header || st_updates >= 2'd2) latch_error(ERR_SIZE);
               else begin_int(CTX_SIZE, 8'h1f, b);
            end else begin
               st_saw_header = 1'b1;
               begin_int(CTX_LIT_PLAIN, 8'h0f, b);
            end
         end
         PH_INT: continue_int(b);
         PH_NAME_LEN, PH_VALUE_LEN: begin
            st_huff = b[7];
            begin_int((st_phase == PH_VALUE_LEN) ? CTX_VALUE_LEN : CTX_NAME_LEN, 8'h7f, b);
         end
         PH_NAME_DATA, PH_VALUE_DATA: begin
            isv = (st_phase == PH_VALUE_DATA);
            emit_token(KIND_PAYLOAD, {24'd0, b}, 1'b0, 1'b0, isv, ERR_NONE);
            st_remaining = st_remaining - 32'd1;
            if (st_remaining == 0) st_phase = isv ? PH_START : PH_VALUE_LEN;
         end
         default: ;
      endcase
      if (r.block_end) begin
         if (st_error != ERR_NONE)
            emit_token(KIND_BLOCK_ERR, '0, 1'b0, 1'b0, 1'b0, st_error);
         else if (st_phase != PH_START)
            emit_token(KIND_BLOCK_ERR, '0, 1'b0, 1'b0, 1'b0, ERR_TRUNC);
         else
            emit_token(KIND_BLOCK_OK, '0, 1'b0, 1'b0, 1'b0, ERR_NONE);
         clear_block();
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
   endfunction

   // ---------------- checking ----------------

   function automatic string fmt_token(rsp_type t);
      return $sformatf("kind %0d value %h huff %b add %b isval %b err %0d last %b",
                       t.token_kind, t.token_value, t.huffman_flag, t.adds_to_table,
                       t.string_is_value, t.error_code, t.last_of_run);
   endfunction

   function automatic void check_token(rsp_type got);
      rsp_type want;
      if (pending_tokens.size() == 0) begin
         $display("%0t: unexpected token, expected none, actual %s", $time, fmt_token(got));
         mismatch_count++;
      end else begin
         want = pending_tokens.pop_front();
         if (got !== want) begin
            $display("%0t: token mismatch, expected %s, actual %s", $time,
                     fmt_token(want), fmt_token(got));
            mismatch_count++;
         end
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      byte_row_type row;
      if (reset) begin
         table_limit = ALLOWED_SIZE_RESET;
         clear_block();
      end else begin
         if (csr_valid && csr_ready) table_limit = csr_data;
         if (req_valid && !req_stall) begin
            row = sent_rows.pop_front();
            tokenize_byte(req_data);
            if (row.n_typed < 0) begin
               foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
            end else begin
               if (row.n_typed > 0) pending_tokens.push_back(row.r0);
               if (row.n_typed > 1) pending_tokens.push_back(row.r1);
            end
         end
         if (rsp_valid && !rsp_stall) check_token(rsp_data);
      end
   end

   // ---------------- stimulus ----------------

   function automatic void add_row(logic [7:0] b, logic last, int n, rsp_type r0,
                                   rsp_type r1);
      byte_row_type row;
      row.req.data_byte = b;
      row.req.block_end = last;
      row.n_typed       = n;
      row.r0            = r0;
      row.r1            = r1;
      byte_rows.push_back(row);
   endfunction

   function automatic void push_byte(logic [7:0] b);
      add_row(b, 1'b0, -1, '0, '0);
   endfunction

   function automatic void build_directed();
      rsp_type blank;
      blank = '0;
      // index zero, then block ok on the same byte
      add_row(8'h80, 1'b1, 2, mk_token(KIND_INDEXED, '0, 0, 0, 0, ERR_NONE, 1'b0),
              mk_token(KIND_BLOCK_OK, '0, 0, 0, 0, ERR_NONE, 1'b1));
      // largest index 0xFFFFFFFF, with a zero continuation chunk
      add_row(8'hFF, 1'b0, -1, blank, blank);
      add_row(8'h80, 1'b0, -1, blank, blank);
      add_row(8'hFF, 1'b0, -1, blank, blank);
      add_row(8'hFF, 1'b0, -1, blank, blank);
      add_row(8'hFF, 1'b0, -1, blank, blank);
      add_row(8'h0F, 1'b0, 1, mk_token(KIND_INDEXED, 32'hFFFFFFFF, 0, 0, 0, ERR_NONE, 1'b1),
              blank);
      // size update after a header
      add_row(8'h21, 1'b0, 0, blank, blank);
      add_row(8'h82, 1'b1, 1, mk_token(KIND_BLOCK_ERR, '0, 0, 0, 0, ERR_SIZE, 1'b1), blank);
      // update to exactly 4096, then a smaller second update
      add_row(8'h3F, 1'b0, -1, blank, blank);
      add_row(8'hE1, 1'b0, -1, blank, blank);
      add_row(8'h1F, 1'b0, -1, blank, blank);
      add_row(8'h3F, 1'b0, -1, blank, blank);
      add_row(8'h00, 1'b1, 1, mk_token(KIND_BLOCK_ERR, '0, 0, 0, 0, ERR_SIZE, 1'b1), blank);
      // incremental indexing, new Huffman name, empty value
      add_row(8'h40, 1'b0, -1, blank, blank);
      add_row(8'h81, 1'b0, -1, blank, blank);
      add_row(8'hAA, 1'b0, -1, blank, blank);
      add_row(8'h00, 1'b1, -1, blank, blank);
      // never indexed, name index 5
      add_row(8'h15, 1'b0, -1, blank, blank);
      add_row(8'h81, 1'b0, -1, blank, blank);
      add_row(8'h7F, 1'b1, -1, blank, blank);
      // integer overflow at the fifth continuation byte
      repeat (5) add_row(8'hFF, 1'b0, -1, blank, blank);
      add_row(8'hFF, 1'b1, 1, mk_token(KIND_BLOCK_ERR, '0, 0, 0, 0, ERR_OVERFLOW, 1'b1),
              blank);
      // truncated inside a literal name index
      add_row(8'h0F, 1'b1, 1, mk_token(KIND_BLOCK_ERR, '0, 0, 0, 0, ERR_TRUNC, 1'b1), blank);
   endfunction

   function automatic int pick_pad();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 20);
         1: return $urandom_range(0, 200);
         2: return $urandom_range(0, 70000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_size(logic [31:0] lim, logic [31:0] prev);
      logic [63:0] span;
      logic [63:0] r;
      span = {32'd0, lim} + 64'd1;
      r = {32'd0, 32'($urandom)} % span;
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return lim;
         2: return prev;
         3: return prev + 32'($urandom_range(0, 50));
         default: return r[31:0];
      endcase
   endfunction

   function automatic void push_int(logic [7:0] head, int nbits, logic [31:0] v, int pad);
      logic [31:0] mask;
      logic [31:0] rem;
      mask = (32'd1 << nbits) - 32'd1;
      if (v < mask) begin
         push_byte(head | v[7:0]);
      end else begin
         push_byte(head | mask[7:0]);
         rem = v - mask;
         while (rem >= 32'd128) begin
            push_byte({1'b1, rem[6:0]});
            rem = rem >> 7;
         end
         if (pad > 0) begin
            push_byte({1'b1, rem[6:0]});
            repeat (pad - 1) push_byte(8'h80);
            push_byte(8'h00);
         end else begin
            push_byte({1'b0, rem[6:0]});
         end
      end
   endfunction

   function automatic void gen_string();
      logic huff;
      int   len;
      huff = 1'($urandom_range(0, 1));
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 5);
      push_int({huff, 7'd0}, 7, len, pick_pad());
      repeat (len) push_byte(8'($urandom));
   endfunction

   function automatic void gen_literal(logic [7:0] head, int nbits);
      logic [31:0] idx;
      idx = ($urandom_range(0, 1) == 0) ? 32'd0 : pick_value();
      push_int(head, nbits, idx, pick_pad());
      if (idx == 0) gen_string();
      gen_string();
   endfunction

   function automatic void gen_block(logic [31:0] lim);
      int          start_at;
      int          n_upd;
      int          n_rep;
      logic [31:0] prev;
      start_at = byte_rows.size();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else begin
         n_upd = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
         prev = '0;
         repeat (n_upd) begin
            prev = pick_size(lim, prev);
            push_int(8'h20, 5, prev, pick_pad());
         end
         n_rep = $urandom_range(1, 4);
         repeat (n_rep) begin
            case ($urandom_range(0, 15))
               0: push_int(8'h20, 5, pick_size(lim, prev), 0);
               1, 2, 3, 4, 5: push_int(8'h80, 7, pick_value(), pick_pad());
               6, 7, 8, 9, 10: gen_literal(8'h40, 6);
               default: gen_literal(($urandom_range(0, 1) != 0) ? 8'h10 : 8'h00, 4);
            endcase
         end
         case ($urandom_range(0, 9))
            0: begin
               if (byte_rows.size() - start_at > 1)
                  repeat ($urandom_range(1, byte_rows.size() - start_at - 1))
                     void'(byte_rows.pop_back());
            end
            1: byte_rows[$urandom_range(start_at, byte_rows.size() - 1)].req.data_byte =
                  8'($urandom);
            2: repeat (7) push_byte(8'hFF);
            default: ;
         endcase
      end
      byte_rows[byte_rows.size() - 1].req.block_end = 1'b1;
   endfunction

   // ---------------- drivers ----------------

   task automatic send_all();
      byte_row_type row;
      int        gap;
      while (byte_rows.size() != 0) begin
         row = byte_rows.pop_front();
         gap = no_idle ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         sent_rows.push_back(row);
         req_valid <= 1'b1;
         req_data  <= row.req;
         do @(posedge clock); while (req_stall);
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_allowed(logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : rsp_side
      int hold;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = 300;
         end else begin
            hold = no_idle ? 0 : $urandom_range(0, 8);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   initial begin : main_seq
      logic [31:0] limits[6];
      int          p;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      build_directed();
      send_all();
      drain();

      limits[0] = 32'hFFFFFFFF;
      limits[1] = 32'd0;
      limits[2] = 32'd4096;
      limits[3] = 32'($urandom_range(0, 300));
      limits[4] = $urandom;
      limits[5] = 32'($urandom_range(1, 70000));
      for (p = 0; p < 6; p++) begin
         write_allowed(limits[p]);
         no_idle       = (p == 2);
         long_hold_req = (p == 1);
         while (byte_rows.size() < 220) gen_block(limits[p]);
         send_all();
         drain();
      end

      if (mismatch_count == 0 && pending_tokens.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
